// ===== rtl/video_test_pattern_generator_defines.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef VIDEO_TEST_PATTERN_GENERATOR_DEFINES_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define VTPG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define VTPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vtpg_pkg.sv =====
`default_nettype none

package vtpg_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int QUOT_W      = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAYER_ENABLE      = 3'd4;

    // Pattern modes.
    localparam logic [1:0] MODE_BG   = 2'd0;
    localparam logic [1:0] MODE_LINE = 2'd1;
    localparam logic [1:0] MODE_GRID = 2'd2;

    // Register reset values.
    localparam logic [1:0]       RST_PATTERN_MODE = MODE_LINE;
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd320;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd240;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_R,
        ST_DIV_R,
        ST_MUL_G,
        ST_DIV_G,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
        logic sel_green;
        logic store_red;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic grid_mode;
        logic div_last;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/video_test_pattern_generator.sv =====
// Grid mode: a pixel passes the accept state, one state for each of the two ramp products,
// eight restoring-division steps per ramp on one shared divider, and a state to load the output.
// Other modes: the accept state and the load state only. The load waits until the output is
// free; the output register holds a result while the next pixel is worked on.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the column, row and marked-row counters.
`default_nettype none

module video_test_pattern_generator #(
    parameter int MAX_DIM = vtpg_pkg::MAX_DIM_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [vtpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vtpg_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,  // bg_red, bg_green, bg_blue
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [31:0]                         m_tdata,  // red, green, blue, bayer_value
    output logic                                m_tlast,  // end_of_line
    output logic                                m_tuser   // end_of_frame
);

    vtpg_pkg::ctrl_cmd_t    cmd;
    vtpg_pkg::ctrl_status_t status;

    vtpg_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    vtpg_datapath #(
        .MAX_DIM(MAX_DIM)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/vtpg_ramp_div.sv =====
`default_nettype none

// Computes round(255 * pos / last), half up, saturated to 255, as
// floor((510 * pos + last) / (2 * last)) with one restoring step per cycle while step is high.
module vtpg_ramp_div #(
    parameter int DIM_W = 12
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         step,
    input  wire logic [DIM_W-1:0]             pos,
    input  wire logic [DIM_W-1:0]             last,
    output logic [vtpg_pkg::QUOT_W-1:0]       quot,
    output logic                              last_step
);

    localparam int NUM_W = DIM_W + 10;
    localparam int CNT_W = $clog2(vtpg_pkg::QUOT_W);

    logic [NUM_W-1:0]            num_reg, num_next;
    logic [NUM_W-1:0]            dsh_reg, dsh_next;
    logic [vtpg_pkg::QUOT_W-1:0] q_reg, q_next;
    logic                        sat_reg, sat_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        fits;

    assign fits      = (num_reg >= dsh_reg);
    assign last_step = (cnt_reg == CNT_W'(vtpg_pkg::QUOT_W - 1));
    assign quot      = sat_reg ? '1 : q_reg;

    always_comb
    begin
        num_next = num_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        sat_next = sat_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            // 510 * pos as a shift and subtract.
            num_next = (NUM_W'(pos) << 9) - (NUM_W'(pos) << 1) + NUM_W'(last);
            dsh_next = NUM_W'(last) << 8;
            sat_next = 1'b0;
            cnt_next = '0;
        end
        else if (step)
        begin
            // The quotient reaches 256 when the numerator is at least 2*last << 8.
            if (cnt_reg == '0)
            begin
                sat_next = (num_reg >= (dsh_reg << 1));
            end
            if (fits)
            begin
                num_next = num_reg - dsh_reg;
            end
            dsh_next = dsh_reg >> 1;
            q_next   = {q_reg[vtpg_pkg::QUOT_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

endmodule

`default_nettype wire

// ===== rtl/vtpg_datapath.sv =====
`default_nettype none

module vtpg_datapath #(
    parameter int MAX_DIM = vtpg_pkg::MAX_DIM_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [vtpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vtpg_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [23:0]                    s_tdata,
    input  wire vtpg_pkg::ctrl_cmd_t            cmd,
    output vtpg_pkg::ctrl_status_t              status,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [31:0]                         m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    localparam int DIM_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int PW    = vtpg_pkg::PIX_W;

    // Configuration registers.
    logic [1:0]                 mode_reg;
    logic [vtpg_pkg::CFG_W-1:0] width_reg;
    logic [vtpg_pkg::CFG_W-1:0] height_reg;
    logic                       bg_en_reg;
    logic                       bayer_en_reg;

    // Raster position.
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] mark_reg, mark_next;

    // Item being worked on.
    logic [23:0]      bg_reg;
    logic [DIM_W-1:0] x_reg;
    logic [DIM_W-1:0] y_reg;
    logic             on_mark_reg;
    logic             eol_reg;
    logic             eof_reg;
    logic [PW-1:0]    red_ramp_reg;

    // Output register.
    logic             out_valid_reg;
    logic [31:0]      out_data_reg;
    logic             out_eol_reg;
    logic             out_eof_reg;

    logic [DIM_W-1:0] last_w;
    logic [DIM_W-1:0] last_h;
    logic             eol;
    logic             eof;
    logic [DIM_W-1:0] div_pos;
    logic [DIM_W-1:0] div_last;
    logic [PW-1:0]    quot;
    logic             div_last_step;
    logic [PW-1:0]    r, g, b, bay;

    // Last position along one axis after the size is limited to [2, MAX_DIM].
    function automatic logic [DIM_W-1:0] last_of(input logic [vtpg_pkg::CFG_W-1:0] dim);
        logic [31:0] d;
        logic [31:0] res;
        d = 32'(dim);
        if (d < 32'd2)
        begin
            res = 32'd1;
        end
        else if (d > 32'(MAX_DIM))
        begin
            res = 32'(MAX_DIM) - 32'd1;
        end
        else
        begin
            res = d - 32'd1;
        end
        return DIM_W'(res);
    endfunction

    assign last_w = last_of(width_reg);
    assign last_h = last_of(height_reg);
    assign eol    = (col_reg >= last_w);
    assign eof    = eol && (row_reg >= last_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= vtpg_pkg::RST_PATTERN_MODE;
            width_reg    <= vtpg_pkg::RST_FRAME_WIDTH;
            height_reg   <= vtpg_pkg::RST_FRAME_HEIGHT;
            bg_en_reg    <= 1'b0;
            bayer_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vtpg_pkg::REG_PATTERN_MODE:      mode_reg     <= cfg_data[1:0];
                vtpg_pkg::REG_FRAME_WIDTH:       width_reg    <= cfg_data;
                vtpg_pkg::REG_FRAME_HEIGHT:      height_reg   <= cfg_data;
                vtpg_pkg::REG_BACKGROUND_ENABLE: bg_en_reg    <= cfg_data[0];
                vtpg_pkg::REG_BAYER_ENABLE:      bayer_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        mark_next = mark_reg;
        if (cmd.accept)
        begin
            if (eol)
            begin
                col_next = '0;
                if (eof)
                begin
                    row_next  = '0;
                    mark_next = (mark_reg >= last_h) ? '0 : mark_reg + DIM_W'(1);
                end
                else
                begin
                    row_next = row_reg + DIM_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            mark_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            bg_reg      <= s_tdata;
            x_reg       <= col_reg;
            y_reg       <= row_reg;
            on_mark_reg <= (row_reg == mark_reg);
            eol_reg     <= eol;
            eof_reg     <= eof;
        end
        if (cmd.store_red)
        begin
            red_ramp_reg <= quot;
        end
    end

    assign div_pos  = cmd.sel_green ? y_reg : x_reg;
    assign div_last = cmd.sel_green ? last_h : last_w;

    vtpg_ramp_div #(
        .DIM_W(DIM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .pos      (div_pos),
        .last     (div_last),
        .quot     (quot),
        .last_step(div_last_step)
    );

    // Final pixel; in grid mode the green ramp is still held by the divider.
    always_comb
    begin
        if (bg_en_reg)
        begin
            r = bg_reg[7:0];
            g = bg_reg[15:8];
            b = bg_reg[23:16];
        end
        else
        begin
            r = '0;
            g = '0;
            b = '0;
        end
        if (mode_reg == vtpg_pkg::MODE_GRID)
        begin
            r = red_ramp_reg;
            g = quot;
            b = on_mark_reg ? '1 : '0;
        end
        else if (mode_reg != vtpg_pkg::MODE_BG)
        begin
            if (on_mark_reg)
            begin
                r = '1;
            end
        end
        bay = '0;
        if (bayer_en_reg)
        begin
            if (!y_reg[0])
            begin
                bay = x_reg[0] ? r : g;
            end
            else
            begin
                bay = x_reg[0] ? g : b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {bay, b, g, r};
            out_eol_reg  <= eol_reg;
            out_eof_reg  <= eof_reg;
        end
    end

    assign status.grid_mode = (mode_reg == vtpg_pkg::MODE_GRID);
    assign status.div_last  = div_last_step;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_eol_reg;
    assign m_tuser  = out_eof_reg;

endmodule

`default_nettype wire

// ===== rtl/vtpg_ctrl.sv =====
`default_nettype none

module vtpg_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire vtpg_pkg::ctrl_status_t status,
    output vtpg_pkg::ctrl_cmd_t         cmd
);

    vtpg_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vtpg_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = status.grid_mode ? vtpg_pkg::ST_MUL_R : vtpg_pkg::ST_DONE;
                end
            end
            vtpg_pkg::ST_MUL_R: state_next = vtpg_pkg::ST_DIV_R;
            vtpg_pkg::ST_DIV_R:
            begin
                if (status.div_last)
                begin
                    state_next = vtpg_pkg::ST_MUL_G;
                end
            end
            vtpg_pkg::ST_MUL_G: state_next = vtpg_pkg::ST_DIV_G;
            vtpg_pkg::ST_DIV_G:
            begin
                if (status.div_last)
                begin
                    state_next = vtpg_pkg::ST_DONE;
                end
            end
            vtpg_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = vtpg_pkg::ST_IDLE;
                end
            end
            default: state_next = vtpg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            vtpg_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            vtpg_pkg::ST_MUL_R:
            begin
                cmd.div_start = 1'b1;
            end
            vtpg_pkg::ST_DIV_R:
            begin
                cmd.div_step = 1'b1;
            end
            vtpg_pkg::ST_MUL_G:
            begin
                // The red quotient is captured on the same edge that restarts the divider.
                cmd.div_start = 1'b1;
                cmd.sel_green = 1'b1;
                cmd.store_red = 1'b1;
            end
            vtpg_pkg::ST_DIV_G:
            begin
                cmd.div_step  = 1'b1;
                cmd.sel_green = 1'b1;
            end
            vtpg_pkg::ST_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vtpg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vtpg_checker.sv =====
`default_nettype none

`include "video_test_pattern_generator_defines.svh"

module vtpg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    logic [33:0] out_w;

    assign out_w = {m_tdata, m_tlast, m_tuser};

    // A frame always ends on the last pixel of a line.
    `VTPG_ASSERT_SAME(a_eof_on_eol, m_tvalid && m_tuser, m_tlast, "end of frame without end of line")

    // Only one pixel is in work at a time.
    `VTPG_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input taken while busy")

    // A new result only appears after a pixel was being worked on.
    `VTPG_ASSERT_SAME(a_out_after_work, $rose(m_tvalid), $past(!s_tready), "result without work")

    `VTPG_ASSERT_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "stalled output dropped")

    `VTPG_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(out_w), "stalled output changed")

endmodule

bind video_test_pattern_generator vtpg_checker u_checker (.*);

`default_nettype wire
